// File: sv/nearest_three_neighbors_3d_assert.svh
// Assertion macros shared by the nearest-neighbor RTL.
`ifndef NEAREST_THREE_NEIGHBORS_3D_ASSERT_SVH
`define NEAREST_THREE_NEIGHBORS_3D_ASSERT_SVH

`ifndef SYNTH

// Check a property while reset is released.
`define N3D_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nearest_three_neighbors_3d: assertion failed");

// Check a property on every edge, reset included.
`define N3D_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("nearest_three_neighbors_3d: assertion failed");

`else

`define N3D_ASSERT(lbl, clk, rst_n, prop)
`define N3D_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: sv/nn3d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nn3d_pkg;

    localparam int MAX_POINTS     = 512;
    localparam int NEIGHBOR_COUNT = 3;
    localparam int COORD_BITS     = 12;

    // Fixed field widths of the interface
    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int CFG_W    = 10;
    localparam int REPORTED = 3;
    localparam int FOUND_W  = 2;

    // Datapath widths
    localparam int PT_W   = 3 * COORD_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 2;
    localparam int FILL_W = $clog2(NEIGHBOR_COUNT + 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic store;
        logic start;
        logic ref_read;
        logic ref_latch;
        logic scan_step;
        logic publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: sv/nearest_three_neighbors_3d.sv
`timescale 1ns / 1ps
`default_nettype none

// Brute-force search for the three nearest neighbors of a stored 3D point.
// A load (command 0) writes one point into the point memory; it gives no
// result. A query (command 1) reads the named point, then streams every
// stored point below num_points through one read port of the point memory,
// one point per cycle, into a four-stage squared-distance pipeline that
// feeds a sorted list of the three best. A query at or above num_points
// skips the scan and reports found_count 0. Ties keep the lower index
// first; unfilled slots read 0. Points are undefined until loaded, so
// load every index below num_points before querying. Write num_points only
// while no query is in flight. The result waits in an output register, so
// the next item is taken while it is still pending.
module nearest_three_neighbors_3d (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     s_valid,
    output logic                                    s_ready,
    input  wire                                     s_command,
    input  wire [nn3d_pkg::IDX_W-1:0]               s_point_index,
    input  wire signed [nn3d_pkg::COORD_BITS-1:0]   s_coord_x,
    input  wire signed [nn3d_pkg::COORD_BITS-1:0]   s_coord_y,
    input  wire signed [nn3d_pkg::COORD_BITS-1:0]   s_coord_z,
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic [nn3d_pkg::IDX_W-1:0]              m_query_index,
    output logic [nn3d_pkg::IDX_W-1:0]              m_nearest_first,
    output logic [nn3d_pkg::IDX_W-1:0]              m_nearest_second,
    output logic [nn3d_pkg::IDX_W-1:0]              m_nearest_third,
    output logic [nn3d_pkg::FOUND_W-1:0]            m_found_count,
    input  wire                                     cfg_we,
    input  wire [nn3d_pkg::CFG_W-1:0]               cfg_wdata
);
    import nn3d_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    nn3d_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .status    (status),
        .cmd       (cmd)
    );

    nn3d_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_point_index    (s_point_index),
        .s_coord_x        (s_coord_x),
        .s_coord_y        (s_coord_y),
        .s_coord_z        (s_coord_z),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_query_index    (m_query_index),
        .m_nearest_first  (m_nearest_first),
        .m_nearest_second (m_nearest_second),
        .m_nearest_third  (m_nearest_third),
        .m_found_count    (m_found_count)
    );

endmodule

`default_nettype wire

// File: sv/nn3d_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_three_neighbors_3d_assert.svh"

module nn3d_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire                     s_command,
    input  wire nn3d_pkg::dp_status_t status,
    output nn3d_pkg::ctrl_cmd_t     cmd
);
    import nn3d_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REF_READ,
        ST_REF_LATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_PUBLISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    if (s_command == CMD_QUERY) begin
                        cmd.start  = 1'b1;
                        // skip the scan for a query outside the stored set
                        state_next = status.in_range ? ST_REF_READ : ST_PUBLISH;
                    end else begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_REF_READ: begin
                cmd.ref_read = 1'b1;
                state_next   = ST_REF_LATCH;
            end
            ST_REF_LATCH: begin
                cmd.ref_latch = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    `N3D_ASSERT(a_publish_after_drain, aclk, aresetn, cmd.publish |-> !status.pipe_busy)
    `N3D_ASSERT(a_publish_has_room, aclk, aresetn, cmd.publish |-> status.out_free)
    `N3D_ASSERT(a_query_blocks_input, aclk, aresetn, (s_valid && s_ready && s_command == CMD_QUERY) |=> !s_ready)
    `N3D_ASSERT(a_scan_only_in_range, aclk, aresetn, (cmd.start && !status.in_range) |=> !cmd.scan_step && !cmd.ref_read)

endmodule

`default_nettype wire

// File: sv/nn3d_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_three_neighbors_3d_assert.svh"

module nn3d_datapath (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire nn3d_pkg::ctrl_cmd_t                cmd,
    output nn3d_pkg::dp_status_t                    status,
    input  wire [nn3d_pkg::IDX_W-1:0]               s_point_index,
    input  wire signed [nn3d_pkg::COORD_BITS-1:0]   s_coord_x,
    input  wire signed [nn3d_pkg::COORD_BITS-1:0]   s_coord_y,
    input  wire signed [nn3d_pkg::COORD_BITS-1:0]   s_coord_z,
    input  wire                                     cfg_we,
    input  wire [nn3d_pkg::CFG_W-1:0]               cfg_wdata,
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic [nn3d_pkg::IDX_W-1:0]              m_query_index,
    output logic [nn3d_pkg::IDX_W-1:0]              m_nearest_first,
    output logic [nn3d_pkg::IDX_W-1:0]              m_nearest_second,
    output logic [nn3d_pkg::IDX_W-1:0]              m_nearest_third,
    output logic [nn3d_pkg::FOUND_W-1:0]            m_found_count
);
    import nn3d_pkg::*;

    // Point memory: x in the top slice, z in the bottom
    logic [PT_W-1:0] mem [MAX_POINTS];
    logic [PT_W-1:0] rdata_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [CNT_W-1:0] num_points_reg;
    logic [31:0]      cfg_wide;
    logic [IDX_W-1:0] qidx_reg;
    logic [CNT_W-1:0] scan_pos_reg;

    logic signed [COORD_BITS-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic signed [COORD_BITS-1:0] pt_x, pt_y, pt_z;

    // Distance pipeline
    logic                     p0_vld_reg, p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [IDX_W-1:0]         p0_idx_reg, p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;
    logic [SQ_W-1:0]          sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DIST_W-1:0]        dist_reg;

    // Sorted neighbor list
    logic [DIST_W-1:0] best_d_reg   [NEIGHBOR_COUNT];
    logic [DIST_W-1:0] best_d_next  [NEIGHBOR_COUNT];
    logic [IDX_W-1:0]  best_i_reg   [NEIGHBOR_COUNT];
    logic [IDX_W-1:0]  best_i_next  [NEIGHBOR_COUNT];
    logic [NEIGHBOR_COUNT-1:0] take;
    logic [FILL_W-1:0] filled_reg;

    logic [IDX_W-1:0]   rep_idx [REPORTED];
    logic [FOUND_W-1:0] found;

    logic               m_valid_reg;
    logic [IDX_W-1:0]   m_query_index_reg;
    logic [IDX_W-1:0]   m_first_reg, m_second_reg, m_third_reg;
    logic [FOUND_W-1:0] m_found_reg;

    assign cfg_wide = 32'(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= '0;
        end else if (cfg_we) begin
            num_points_reg <= (cfg_wide > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                           : CNT_W'(cfg_wide);
        end
    end

    assign status.in_range  = CNT_W'(s_point_index) < num_points_reg;
    assign status.scan_last = scan_pos_reg == (num_points_reg - CNT_W'(1));
    assign status.pipe_busy = p0_vld_reg || p1_vld_reg || p2_vld_reg || p3_vld_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign rd_addr = cmd.ref_read ? qidx_reg : scan_pos_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.store && (32'(s_point_index) < 32'(MAX_POINTS))) begin
            mem[s_point_index] <= {s_coord_x, s_coord_y, s_coord_z};
        end
        if (cmd.ref_read || cmd.scan_step) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign pt_x = signed'(rdata_reg[3*COORD_BITS-1:2*COORD_BITS]);
    assign pt_y = signed'(rdata_reg[2*COORD_BITS-1:COORD_BITS]);
    assign pt_z = signed'(rdata_reg[COORD_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            qidx_reg <= s_point_index;
        end
        if (cmd.ref_latch) begin
            ref_x_reg <= pt_x;
            ref_y_reg <= pt_y;
            ref_z_reg <= pt_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_pos_reg <= '0;
        end else if (cmd.start) begin
            scan_pos_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_pos_reg <= scan_pos_reg + CNT_W'(1);
        end
    end

    assign prod_x = (2*DIFF_W)'(dx_reg) * (2*DIFF_W)'(dx_reg);
    assign prod_y = (2*DIFF_W)'(dy_reg) * (2*DIFF_W)'(dy_reg);
    assign prod_z = (2*DIFF_W)'(dz_reg) * (2*DIFF_W)'(dz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else begin
            // drop the queried point itself
            p0_vld_reg <= cmd.scan_step && (scan_pos_reg[IDX_W-1:0] != qidx_reg);
            p1_vld_reg <= p0_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p0_idx_reg <= scan_pos_reg[IDX_W-1:0];
        p1_idx_reg <= p0_idx_reg;
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        dx_reg     <= DIFF_W'(ref_x_reg) - DIFF_W'(pt_x);
        dy_reg     <= DIFF_W'(ref_y_reg) - DIFF_W'(pt_y);
        dz_reg     <= DIFF_W'(ref_z_reg) - DIFF_W'(pt_z);
        sq_x_reg   <= prod_x[SQ_W-1:0];
        sq_y_reg   <= prod_y[SQ_W-1:0];
        sq_z_reg   <= prod_z[SQ_W-1:0];
        dist_reg   <= DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
    end

    // Strict less-than keeps the earlier index ahead on a tie
    always_comb begin
        for (int k = 0; k < NEIGHBOR_COUNT; k++) begin
            take[k] = (FILL_W'(k) >= filled_reg) || (dist_reg < best_d_reg[k]);
        end
        for (int l = 0; l < NEIGHBOR_COUNT; l++) begin
            if (l > 0 && take[(l > 0) ? l - 1 : 0]) begin
                best_d_next[l] = best_d_reg[(l > 0) ? l - 1 : 0];
                best_i_next[l] = best_i_reg[(l > 0) ? l - 1 : 0];
            end else if (take[l]) begin
                best_d_next[l] = dist_reg;
                best_i_next[l] = p3_idx_reg;
            end else begin
                best_d_next[l] = best_d_reg[l];
                best_i_next[l] = best_i_reg[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
        end else if (cmd.start) begin
            filled_reg <= '0;
        end else if (p3_vld_reg && (32'(filled_reg) < 32'(NEIGHBOR_COUNT))) begin
            filled_reg <= filled_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.start) begin
            for (int l = 0; l < NEIGHBOR_COUNT; l++) begin
                best_d_reg[l] <= '1;
                best_i_reg[l] <= '0;
            end
        end else if (p3_vld_reg) begin
            for (int l = 0; l < NEIGHBOR_COUNT; l++) begin
                best_d_reg[l] <= best_d_next[l];
                best_i_reg[l] <= best_i_next[l];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < REPORTED; k++) begin
            rep_idx[k] = '0;
            if (k < NEIGHBOR_COUNT && (32'(k) < 32'(filled_reg))) begin
                rep_idx[k] = best_i_reg[(k < NEIGHBOR_COUNT) ? k : 0];
            end
        end
        found = (32'(filled_reg) > 32'(REPORTED)) ? FOUND_W'(REPORTED)
                                                  : FOUND_W'(filled_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_query_index_reg <= qidx_reg;
            m_first_reg       <= rep_idx[0];
            m_second_reg      <= rep_idx[1];
            m_third_reg       <= rep_idx[2];
            m_found_reg       <= found;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_query_index    = m_query_index_reg;
    assign m_nearest_first  = m_first_reg;
    assign m_nearest_second = m_second_reg;
    assign m_nearest_third  = m_third_reg;
    assign m_found_count    = m_found_reg;

    `N3D_ASSERT(a_scan_below_count, aclk, aresetn, p0_vld_reg |-> (CNT_W'(p0_idx_reg) < num_points_reg))
    `N3D_ASSERT(a_fill_bounded, aclk, aresetn, 32'(filled_reg) <= 32'(NEIGHBOR_COUNT))
    `N3D_ASSERT(a_publish_shows, aclk, aresetn, cmd.publish |=> m_valid)
    `N3D_ASSERT(a_clear_on_start, aclk, aresetn, cmd.start |=> (filled_reg == '0) && !p0_vld_reg)

endmodule

`default_nettype wire
